// File: rtl/core/tlbl_pkg.sv
`timescale 1ns / 1ps

package tlbl_pkg;

  localparam int PID_W      = 8;
  localparam int PAGE_W     = 14;
  localparam int FRAME_W    = 14;
  localparam int SLOT_W     = 4;
  localparam int STAMP_W    = 32;
  localparam int IN_DATA_W  = 40;  // pid + page + new_frame = 36, padded to bytes
  localparam int OUT_DATA_W = 24;  // frame + slot = 18, padded to bytes

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_SCAN,
    ST_FILL,
    ST_RESP
  } tlbl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the incoming item
    logic compare;    // register tag match result, read frame
    logic stamp_hit;  // stamp the matching entry
    logic scan;       // one step of the victim search
    logic fill;       // write the victim entry
    logic load_out;   // load the result register
  } tlbl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic insert;
    logic scan_done;
    logic out_busy;
  } tlbl_sts_t;

endpackage

// File: rtl/core/tlbl_ctrl.sv
`timescale 1ns / 1ps

module tlbl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tlbl_pkg::tlbl_sts_t sts,
  output tlbl_pkg::tlbl_cmd_t cmd
);
  import tlbl_pkg::*;

  tlbl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.hit) state_nxt = ST_UPD;
        else if (sts.insert) state_nxt = ST_SCAN;
        else state_nxt = ST_RESP;
      end
      ST_UPD:  state_nxt = ST_RESP;
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_FILL;
      end
      ST_FILL: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_CMP:  cmd.compare   = 1'b1;
      ST_UPD:  cmd.stamp_hit = 1'b1;
      ST_SCAN: cmd.scan      = 1'b1;
      ST_FILL: cmd.fill      = 1'b1;
      ST_RESP: cmd.load_out  = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/tlbl_dp.sv
`timescale 1ns / 1ps

module tlbl_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_command,
  input  logic [tlbl_pkg::PID_W-1:0]   in_pid,
  input  logic [tlbl_pkg::PAGE_W-1:0]  in_page,
  input  logic [tlbl_pkg::FRAME_W-1:0] in_new_frame,
  input  tlbl_pkg::tlbl_cmd_t          cmd,
  output tlbl_pkg::tlbl_sts_t          sts,
  input  logic                         out_tready,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [tlbl_pkg::FRAME_W-1:0] out_frame,
  output logic [tlbl_pkg::SLOT_W-1:0]  out_slot
);
  import tlbl_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // item being worked on
  logic               command_r;
  logic [PID_W-1:0]   pid_r;
  logic [PAGE_W-1:0]  page_r;
  logic [FRAME_W-1:0] nfr_r;

  // tags in flops, compared in parallel
  logic [ENTRIES-1:0] valid_r;
  logic [PID_W-1:0]   tag_pid_r  [ENTRIES];
  logic [PAGE_W-1:0]  tag_page_r [ENTRIES];

  // frame and stamp storage
  logic [FRAME_W-1:0] frame_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [FRAME_W-1:0] frame_q;
  logic [STAMP_W-1:0] stamp_q;

  logic [STAMP_W-1:0] ctr_r;
  logic [STAMP_W-1:0] stamp_val;

  logic [ENTRIES-1:0] match_vec;
  logic               match_hit;
  logic [AW-1:0]      match_idx;

  logic               hit_r;
  logic [AW-1:0]      idx_r;

  logic [CW-1:0]      cnt_r;
  logic [AW-1:0]      rd_idx;
  logic [STAMP_W-1:0] cand;
  logic [STAMP_W-1:0] best_r;
  logic [AW-1:0]      best_idx_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [SLOT_W-1:0]  slot_w;
  logic               stamp_we;
  logic [AW-1:0]      stamp_wa;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      command_r <= in_command;
      pid_r     <= in_pid;
      page_r    <= in_page;
      nfr_r     <= in_new_frame;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (tag_pid_r[i] == pid_r) && (tag_page_r[i] == page_r);
    end
  end

  // lowest matching index wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_hit = 1'b1;
        match_idx = AW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit_r <= match_hit;
    end
    if (cmd.compare) begin
      idx_r <= match_idx;
    end else if (cmd.fill) begin
      idx_r <= best_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.fill) begin
      valid_r[best_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      tag_pid_r[best_idx_r]  <= pid_r;
      tag_page_r[best_idx_r] <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      frame_mem[best_idx_r] <= nfr_r;
    end
    if (cmd.compare) begin
      frame_q <= frame_mem[match_idx];
    end
  end

  assign stamp_val = ctr_r + 1'b1;
  assign stamp_we  = cmd.stamp_hit || cmd.fill;
  assign stamp_wa  = cmd.fill ? best_idx_r : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (stamp_we) begin
      ctr_r <= stamp_val;
    end
  end

  // invalid entries read as stamp zero through the valid mask on the read data
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= stamp_val;
    end
    stamp_q <= stamp_mem[cnt_r[AW-1:0]];
  end

  // victim search: address cnt issued, data of cnt-1 compared
  assign rd_idx = AW'(cnt_r - 1'b1);
  assign cand   = valid_r[rd_idx] ? stamp_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.compare) begin
      cnt_r <= '0;
    end else if (cmd.scan && !sts.scan_done) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && (cnt_r != '0)) begin
      if ((cnt_r == CW'(1)) || (cand < best_r)) begin
        best_r     <= cand;
        best_idx_r <= rd_idx;
      end
    end
  end

  generate
    if (AW >= SLOT_W) begin : g_slot_trunc
      assign slot_w = idx_r[SLOT_W-1:0];
    end else begin : g_slot_ext
      assign slot_w = {{(SLOT_W - AW){1'b0}}, idx_r};
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r   <= hit_r;
      out_frame_r <= (hit_r && (command_r == CMD_LOOKUP)) ? frame_q : '0;
      out_slot_r  <= slot_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_frame = out_frame_r;
  assign out_slot  = out_slot_r;

  assign sts.hit       = match_hit;
  assign sts.insert    = (command_r == CMD_INSERT);
  assign sts.scan_done = (cnt_r == CW'(ENTRIES));
  assign sts.out_busy  = out_valid_r && !out_tready;

  // inserts only happen on a miss, so a tag never sits in two entries
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compare |-> $onehot0(match_vec))
    else $error("tag matched more than one entry");

  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    stamp_we |=> (ctr_r == $past(ctr_r) + 1'b1))
    else $error("access counter did not advance on stamping");

  a_ctr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stamp_we |=> $stable(ctr_r))
    else $error("access counter moved without stamping");

  a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |=> valid_r[$past(best_idx_r)])
    else $error("filled entry not marked valid");

endmodule

// File: rtl/core/tlb_lru_fully_associative.sv
`timescale 1ns / 1ps
// Channel | Dir | Ports                       | Contents
// in_     | in  | tvalid tready tdata tuser   | tuser: command; tdata: pid, page, new_frame
// out_    | out | tvalid tready tdata tuser   | tuser: hit; tdata: frame, slot
//
// Hit (lookup or insert): after the input transfer the item passes compare, stamp and
// load; lookup miss: compare and load. Insert miss: the victim search reads the stamp
// memory one entry per cycle behind a registered read, then fills and loads.
// One item in flight; in_tready returns the cycle after the result is loaded. Reset clears
// valid bits and the access counter.
// A stalled output holds its result; the item waits in the response state with in_tready low.

module tlb_lru_fully_associative #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tlbl_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] pid, [21:8] page, [35:22] new_frame
  input  logic                               in_tuser,   // [0] command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlbl_pkg::OUT_DATA_W-1:0]    out_tdata,  // [13:0] frame, [17:14] slot
  output logic                               out_tuser   // [0] hit
);
  import tlbl_pkg::*;

  tlbl_cmd_t          cmd;
  tlbl_sts_t          sts;
  logic               res_hit;
  logic [FRAME_W-1:0] res_frame;
  logic [SLOT_W-1:0]  res_slot;

  tlbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlbl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_command   (in_tuser),
    .in_pid       (in_tdata[PID_W-1:0]),
    .in_page      (in_tdata[PID_W+PAGE_W-1:PID_W]),
    .in_new_frame (in_tdata[PID_W+PAGE_W+FRAME_W-1:PID_W+PAGE_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_hit      (res_hit),
    .out_frame    (res_frame),
    .out_slot     (res_slot)
  );

  assign out_tuser = res_hit;
  assign out_tdata = {{(OUT_DATA_W - FRAME_W - SLOT_W){1'b0}}, res_slot, res_frame};

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import tlbl_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int N_RANDOM  = 1680;
  localparam int MAX_CYC   = 400000;
  localparam int HOLD_CYC  = 150;
  localparam int MAX_PRINT = 200;

  typedef struct packed {
    logic               cmd;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] nframe;
  } xlat_req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  slot;
  } xlat_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  tlb_lru_fully_associative #(.ENTRIES(ENTRIES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // predicted translation buffer contents
  logic               tag_valid [ENTRIES];
  logic [PID_W-1:0]   tag_pid   [ENTRIES];
  logic [PAGE_W-1:0]  tag_page  [ENTRIES];
  logic [FRAME_W-1:0] tag_frame [ENTRIES];
  logic [STAMP_W-1:0] tag_stamp [ENTRIES];
  logic [STAMP_W-1:0] use_count;

  xlat_req_t req_q[$];
  xlat_rsp_t expect_q[$];
  xlat_req_t cur_req;

  int n_in, n_out, errors, cycles;
  int n_lookup_hit, n_lookup_miss, n_refresh, n_fill, n_evict;
  int hold_left;
  bit hold_done;

  // random key pool for the stimulus
  logic [PID_W-1:0]  pool_pid  [40];
  logic [PAGE_W-1:0] pool_page [40];

  initial begin
    forever #4 clk = ~clk;
  end

  // no idling while this many items are going in
  function automatic bit idle_now();
    if (n_in >= 900 && n_in < 1250) return 1'b0;
    return $urandom_range(0, 99) < 38;
  endfunction

  function automatic xlat_rsp_t translate(xlat_req_t r);
    xlat_rsp_t rsp;
    int match;
    int victim;
    rsp = '0;
    match = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (match < 0 && tag_valid[i] && tag_pid[i] == r.pid && tag_page[i] == r.page)
        match = i;
    if (match >= 0) begin
      use_count = use_count + 1'b1;
      tag_stamp[match] = use_count;
      rsp.hit = 1'b1;
      rsp.slot = SLOT_W'(match);
      if (r.cmd == CMD_LOOKUP) begin
        rsp.frame = tag_frame[match];
        n_lookup_hit++;
      end else begin
        n_refresh++;
      end
    end else if (r.cmd == CMD_INSERT) begin
      // least recently stamped entry, lowest index on ties
      victim = 0;
      for (int i = 1; i < ENTRIES; i++)
        if (tag_stamp[i] < tag_stamp[victim]) victim = i;
      if (tag_valid[victim]) n_evict++;
      n_fill++;
      tag_valid[victim] = 1'b1;
      tag_pid[victim]   = r.pid;
      tag_page[victim]  = r.page;
      tag_frame[victim] = r.nframe;
      use_count = use_count + 1'b1;
      tag_stamp[victim] = use_count;
      rsp.slot = SLOT_W'(victim);
    end else begin
      n_lookup_miss++;
    end
    return rsp;
  endfunction

  function automatic xlat_req_t mk_req(logic cmd, int pid, int page, int nframe);
    xlat_req_t r;
    r.cmd    = cmd;
    r.pid    = PID_W'(pid);
    r.page   = PAGE_W'(page);
    r.nframe = FRAME_W'(nframe);
    return r;
  endfunction

  // driver: one item offered at a time, predicted when the transfer happens
  always @(posedge clk) begin : feed
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expect_q.push_back(translate(cur_req));
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() > 0 && !idle_now()) begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_req.cmd;
          in_tdata  <= {{(IN_DATA_W - PID_W - PAGE_W - FRAME_W){1'b0}},
                        cur_req.nframe, cur_req.page, cur_req.pid};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : check_out
    xlat_rsp_t got;
    xlat_rsp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.hit   = out_tuser;
        got.frame = out_tdata[FRAME_W-1:0];
        got.slot  = out_tdata[FRAME_W +: SLOT_W];
        n_out++;
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= MAX_PRINT)
            $display("%0t: unexpected result hit=%b frame=%h slot=%h",
                     $time, got.hit, got.frame, got.slot);
        end else begin
          want = expect_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_PRINT) begin
              if (got.hit !== want.hit)
                $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
              if (got.frame !== want.frame)
                $display("%0t: frame expected %h actual %h", $time, want.frame, got.frame);
              if (got.slot !== want.slot)
                $display("%0t: slot expected %h actual %h", $time, want.slot, got.slot);
            end
          end
        end
      end
      // one long back-pressure stretch so the block stalls its input
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && n_out >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYC;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !idle_now();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == MAX_CYC) begin
      $display("timeout: %0d items in, %0d results out", n_in, n_out);
      $display("tb failed");
      $finish;
    end
  end

  initial begin : stim
    int pool_n;
    int k;
    int pick;
    logic cmd;

    for (int i = 0; i < ENTRIES; i++) begin
      tag_valid[i] = 1'b0;
      tag_pid[i]   = '1;
      tag_page[i]  = '1;
      tag_frame[i] = '1;
      tag_stamp[i] = '0;
    end
    use_count = '0;

    // directed: empty lookups, extreme tags, refresh keeps frame, fill then evict
    req_q.push_back(mk_req(CMD_LOOKUP, 255, 16383, 0));
    req_q.push_back(mk_req(CMD_LOOKUP, 0, 0, 16383));
    req_q.push_back(mk_req(CMD_INSERT, 255, 16383, 16383));
    req_q.push_back(mk_req(CMD_INSERT, 0, 0, 0));
    req_q.push_back(mk_req(CMD_LOOKUP, 255, 16383, 0));
    req_q.push_back(mk_req(CMD_LOOKUP, 0, 0, 0));
    req_q.push_back(mk_req(CMD_INSERT, 0, 0, 'h2aaa));
    req_q.push_back(mk_req(CMD_LOOKUP, 0, 0, 'h1555));
    req_q.push_back(mk_req(CMD_LOOKUP, 1, 0, 0));
    req_q.push_back(mk_req(CMD_LOOKUP, 0, 1, 0));
    for (int i = 2; i < ENTRIES; i++)
      req_q.push_back(mk_req(CMD_INSERT, 'h55 ^ i, 'h2aaa ^ i, (i & 1) ? 'h1555 : 'h2aaa));
    req_q.push_back(mk_req(CMD_INSERT, 'haa, 'h1555, 'h3fff));
    req_q.push_back(mk_req(CMD_LOOKUP, 255, 16383, 0));

    // random: phases over key pools of varying size relative to the entry count
    pool_n = 8;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       pool_n = 8;
          1:       pool_n = 16;
          2:       pool_n = 20;
          default: pool_n = 40;
        endcase
        k = $urandom_range(0, 7);
        for (int i = 0; i < 40; i++) begin
          // a few pids shared across pages so pid and page mismatch on their own
          pool_pid[i]  = (i < 20) ? PID_W'($urandom_range(0, 3) + k) : PID_W'($urandom);
          pool_page[i] = (i % 3 == 0) ? PAGE_W'(i) : PAGE_W'($urandom);
        end
      end
      cmd = ($urandom_range(0, 99) < 55) ? CMD_LOOKUP : CMD_INSERT;
      if ($urandom_range(0, 99) < 10) begin
        req_q.push_back(mk_req(cmd, $urandom, $urandom, $urandom));
      end else begin
        pick = $urandom_range(0, pool_n - 1);
        req_q.push_back(mk_req(cmd, pool_pid[pick], pool_page[pick], $urandom));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_tvalid) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 20) @(posedge clk);

    $display("covered %0d transfers: lookups %0d hit / %0d miss, inserts %0d refresh / %0d fill",
             n_in, n_lookup_hit, n_lookup_miss, n_refresh, n_fill);
    $display("%0d fills replaced a live entry; %0d mismatches", n_evict, errors);
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
